// ----- hw/rtl/dllce_pkg.sv -----
// Shared types and constants for the doubly linked list cursor engine.
// Holds operation codes, controller phases and the control/status structs.
// No dependencies.
package dllce_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  // Operation codes as carried on func; unused codes fold onto OP_NOP
  typedef enum logic [4:0] {
    OP_CLEAR     = 5'd0,
    OP_INS_FIRST = 5'd1,
    OP_INS_LAST  = 5'd2,
    OP_CUR_FIRST = 5'd3,
    OP_CUR_LAST  = 5'd4,
    OP_GET_FIRST = 5'd5,
    OP_GET_LAST  = 5'd6,
    OP_DEL_FIRST = 5'd7,
    OP_DEL_LAST  = 5'd8,
    OP_DEL_AFTER = 5'd9,
    OP_DEL_BEF   = 5'd10,
    OP_INS_AFTER = 5'd11,
    OP_INS_BEF   = 5'd12,
    OP_GET_ACT   = 5'd13,
    OP_SET_ACT   = 5'd14,
    OP_CUR_PREV  = 5'd15,
    OP_CUR_NEXT  = 5'd16,
    OP_IS_ACT    = 5'd17,
    OP_NOP       = 5'd31
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_WR1,
    ST_WR2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t    op;
    state_t phase;
    logic   load;
    logic   set_err;
  } cmd_t;

  typedef struct packed {
    logic head_nil;
    logic tail_nil;
    logic cur_nil;
    logic cur_is_head;
    logic cur_is_tail;
    logic pool_full;
    logic rd_next_nil;
    logic rd_prev_nil;
  } status_t;

endpackage

// ----- hw/rtl/dllce_ctrl.sv -----
// Controller for the doubly linked list engine: sequences each operation
// through read and write phases. Depends on dllce_pkg.
module dllce_ctrl import dllce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [4:0] func,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;
  op_t    op, op_next;
  op_t    op_dec;

  // Decode the operation code
  always_comb begin
    case (func) inside
      [5'd0:5'd17]: op_dec = op_t'(func);
      default:      op_dec = OP_NOP;
    endcase
  end

  // Hold state and latched operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NOP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // Advance through the phases
  always_comb begin
    state_next  = state;
    op_next     = op;
    cmd.op      = op;
    cmd.phase   = state;
    cmd.load    = 1'b0;
    cmd.set_err = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          op_next    = op_dec;
          state_next = ST_RD1;
        end
      end
      ST_RD1: begin
        state_next = ST_RD2;
        case (op)
          OP_CLEAR, OP_CUR_FIRST, OP_CUR_LAST, OP_IS_ACT, OP_NOP:
            state_next = ST_FINISH;
          OP_INS_AFTER, OP_INS_BEF, OP_CUR_PREV, OP_CUR_NEXT:
            if (status.cur_nil) state_next = ST_FINISH;
          OP_GET_FIRST: if (status.head_nil) begin
            cmd.set_err = 1'b1;
            state_next  = ST_FINISH;
          end
          OP_GET_LAST: if (status.tail_nil) begin
            cmd.set_err = 1'b1;
            state_next  = ST_FINISH;
          end
          OP_GET_ACT: if (status.cur_nil) begin
            cmd.set_err = 1'b1;
            state_next  = ST_FINISH;
          end
          OP_DEL_FIRST: if (status.head_nil) state_next = ST_FINISH;
          OP_DEL_LAST:  if (status.tail_nil) state_next = ST_FINISH;
          OP_DEL_AFTER:
            if (status.cur_nil || status.cur_is_tail) state_next = ST_FINISH;
          OP_DEL_BEF:
            if (status.cur_nil || status.cur_is_head) state_next = ST_FINISH;
          OP_SET_ACT:
            state_next = status.cur_nil ? ST_FINISH : ST_WR1;
          default: ;
        endcase
      end
      ST_RD2: begin
        state_next = ST_FINISH;
        case (op)
          OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEF: begin
            if (status.pool_full) cmd.set_err = 1'b1;
            else                  state_next = ST_WR1;
          end
          OP_DEL_FIRST, OP_DEL_LAST: state_next = ST_WR1;
          OP_DEL_AFTER: if (!status.rd_next_nil) state_next = ST_WR1;
          OP_DEL_BEF:   if (!status.rd_prev_nil) state_next = ST_WR1;
          default: ;
        endcase
      end
      ST_WR1: state_next = (op == OP_SET_ACT) ? ST_FINISH : ST_WR2;
      ST_WR2: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FINISH);

endmodule

// ----- hw/rtl/dllce_dpath.sv -----
// Datapath for the doubly linked list engine: node memories, list pointers,
// free chain, bump pointer and result registers. Depends on dllce_pkg.
module dllce_dpath import dllce_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic signed [31:0] data_in,
  output status_t            status,
  output logic signed [31:0] value_out,
  output logic               error,
  output logic               active
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [31:0]   node_value [CAPACITY];
  logic [IW-1:0] node_next  [CAPACITY];
  logic [IW-1:0] node_prev  [CAPACITY];

  logic [IW-1:0] head, tail, cur, fhead, bump, nn, mm;
  logic [31:0]   dat;
  logic [31:0]   rv;
  logic [IW-1:0] rn, rp;

  logic          re;
  logic [IW-1:0] ra;
  logic          we_v, we_n, we_p;
  logic [IW-1:0] wa_v, wa_n, wa_p;
  logic [IW-1:0] wd_n, wd_p;

  // Status towards the controller
  assign status.head_nil    = (head >= NIL);
  assign status.tail_nil    = (tail >= NIL);
  assign status.cur_nil     = (cur >= NIL);
  assign status.cur_is_head = (cur == head);
  assign status.cur_is_tail = (cur == tail);
  assign status.pool_full   = (fhead >= NIL) && (bump >= NIL);
  assign status.rd_next_nil = (rn >= NIL);
  assign status.rd_prev_nil = (rp >= NIL);

  assign active = (cur < NIL);

  // Select memory read address
  always_comb begin
    re = 1'b0;
    ra = cur;
    if (cmd.phase == ST_RD1) begin
      re = 1'b1;
      case (cmd.op)
        OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEF: ra = fhead;
        OP_GET_FIRST, OP_DEL_FIRST: ra = head;
        OP_GET_LAST, OP_DEL_LAST:   ra = tail;
        default: ra = cur;
      endcase
    end else if (cmd.phase == ST_RD2) begin
      case (cmd.op)
        OP_INS_AFTER, OP_INS_BEF: begin
          re = 1'b1;
          ra = cur;
        end
        OP_DEL_AFTER: begin
          re = 1'b1;
          ra = rn;
        end
        OP_DEL_BEF: begin
          re = 1'b1;
          ra = rp;
        end
        default: ;
      endcase
    end
  end

  // Select memory writes
  always_comb begin
    we_v = 1'b0;
    we_n = 1'b0;
    we_p = 1'b0;
    wa_v = nn;
    wa_n = nn;
    wa_p = nn;
    wd_n = NIL;
    wd_p = NIL;
    if (cmd.phase == ST_WR1) begin
      case (cmd.op)
        OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEF: begin
          we_v = 1'b1;
          we_n = 1'b1;
          we_p = 1'b1;
          case (cmd.op)
            OP_INS_FIRST: begin
              wd_n = head;
              wd_p = NIL;
            end
            OP_INS_LAST: begin
              wd_n = NIL;
              wd_p = tail;
            end
            OP_INS_AFTER: begin
              wd_n = rn;
              wd_p = cur;
            end
            default: begin
              wd_n = cur;
              wd_p = rp;
            end
          endcase
        end
        OP_DEL_FIRST: if (head != tail) begin
          we_p = 1'b1;
          wa_p = rn;
          wd_p = NIL;
        end
        OP_DEL_LAST: if (head != tail) begin
          we_n = 1'b1;
          wa_n = rp;
          wd_n = NIL;
        end
        OP_DEL_AFTER: begin
          we_n = 1'b1;
          wa_n = cur;
          wd_n = rn;
          if (!(nn == tail || rn >= NIL)) begin
            we_p = 1'b1;
            wa_p = rn;
            wd_p = cur;
          end
        end
        OP_DEL_BEF: begin
          we_p = 1'b1;
          wa_p = cur;
          wd_p = rp;
          if (!(nn == head || rp >= NIL)) begin
            we_n = 1'b1;
            wa_n = rp;
            wd_n = cur;
          end
        end
        OP_SET_ACT: begin
          we_v = 1'b1;
          wa_v = cur;
        end
        default: ;
      endcase
    end else if (cmd.phase == ST_WR2) begin
      case (cmd.op)
        OP_INS_FIRST: if (head < NIL) begin
          we_p = 1'b1;
          wa_p = head;
          wd_p = nn;
        end
        OP_INS_LAST: if (tail < NIL) begin
          we_n = 1'b1;
          wa_n = tail;
          wd_n = nn;
        end
        OP_INS_AFTER: begin
          we_n = 1'b1;
          wa_n = cur;
          wd_n = nn;
          if (!(cur == tail || mm >= NIL)) begin
            we_p = 1'b1;
            wa_p = mm;
            wd_p = nn;
          end
        end
        OP_INS_BEF: begin
          we_p = 1'b1;
          wa_p = cur;
          wd_p = nn;
          if (!(cur == head || mm >= NIL)) begin
            we_n = 1'b1;
            wa_n = mm;
            wd_n = nn;
          end
        end
        OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AFTER, OP_DEL_BEF: begin
          we_n = 1'b1;
          wa_n = nn;
          wd_n = fhead;
        end
        default: ;
      endcase
    end
  end

  // Node memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_v) node_value[wa_v[AW-1:0]] <= dat;
    if (we_n) node_next[wa_n[AW-1:0]]  <= wd_n;
    if (we_p) node_prev[wa_p[AW-1:0]]  <= wd_p;
    if (re) begin
      rv <= node_value[ra[AW-1:0]];
      rn <= node_next[ra[AW-1:0]];
      rp <= node_prev[ra[AW-1:0]];
    end
  end

  // Transfer payload and latch results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dat       <= data_in;
      value_out <= '0;
    end else if (cmd.phase == ST_RD2 && (cmd.op == OP_GET_FIRST ||
                 cmd.op == OP_GET_LAST || cmd.op == OP_GET_ACT)) begin
      value_out <= rv;
    end
    if (cmd.phase == ST_WR1 && (cmd.op == OP_INS_AFTER || cmd.op == OP_INS_BEF))
      mm <= (cmd.op == OP_INS_AFTER) ? rn : rp;
  end

  // Update list pointers, free chain and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NIL;
      tail  <= NIL;
      cur   <= NIL;
      fhead <= NIL;
      bump  <= '0;
      nn    <= NIL;
      error <= 1'b0;
    end else begin
      if (cmd.load) error <= 1'b0;
      else if (cmd.set_err) error <= 1'b1;
      case (cmd.phase)
        ST_RD1: begin
          case (cmd.op)
            OP_CLEAR: begin
              head  <= NIL;
              tail  <= NIL;
              cur   <= NIL;
              fhead <= NIL;
              bump  <= '0;
            end
            OP_CUR_FIRST: cur <= head;
            OP_CUR_LAST:  cur <= tail;
            OP_DEL_FIRST: nn <= head;
            OP_DEL_LAST:  nn <= tail;
            default: ;
          endcase
        end
        ST_RD2: begin
          case (cmd.op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AFTER, OP_INS_BEF: begin
              if (fhead < NIL) begin
                nn    <= fhead;
                fhead <= rn;
              end else if (bump < NIL) begin
                nn   <= bump;
                bump <= bump + 1'b1;
              end
            end
            OP_DEL_AFTER: nn <= rn;
            OP_DEL_BEF:   nn <= rp;
            OP_CUR_PREV:  cur <= rp;
            OP_CUR_NEXT:  cur <= rn;
            default: ;
          endcase
        end
        ST_WR1: begin
          case (cmd.op)
            OP_DEL_FIRST, OP_DEL_LAST: begin
              if (cur == nn) cur <= NIL;
              if (head == tail) begin
                head <= NIL;
                tail <= NIL;
              end else if (cmd.op == OP_DEL_FIRST) begin
                head <= rn;
              end else begin
                tail <= rp;
              end
            end
            OP_DEL_AFTER: if (nn == tail || rn >= NIL) tail <= cur;
            OP_DEL_BEF:   if (nn == head || rp >= NIL) head <= cur;
            default: ;
          endcase
        end
        ST_WR2: begin
          case (cmd.op)
            OP_INS_FIRST: begin
              if (head >= NIL) tail <= nn;
              head <= nn;
            end
            OP_INS_LAST: begin
              if (tail >= NIL) head <= nn;
              tail <= nn;
            end
            OP_INS_AFTER: if (cur == tail || mm >= NIL) tail <= nn;
            OP_INS_BEF:   if (cur == head || mm >= NIL) head <= nn;
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AFTER, OP_DEL_BEF: fhead <= nn;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/doubly_linked_list_cursor_engine.sv -----
// Top level of the doubly linked list cursor engine.
// Joins dllce_ctrl and dllce_dpath; depends on dllce_pkg.
//
// Usage:
//   Raise start with func and data_in while busy is low; the operation is
//   taken at that clock edge and busy rises on the next cycle.
//   Each operation gives one result: done is high for exactly one cycle,
//   with value_out, error and active valid in that cycle. The receiver
//   cannot stall, so the result must be taken then.
//   Clear, cursor moves to an end, is-active and unused codes go from the
//   first read phase straight to finish; gets and cursor steps may add a second
//   read phase, set value a write phase, and inserts and deletes up to two
//   read and two write phases. A new operation may be transferred in the
//   cycle after done. The node memories set this: every pointer read is
//   registered and every pair of writes to one node memory needs its own cycle.
//   Reset (rst, synchronous) empties the list and pool; node memories are
//   not cleared.
module doubly_linked_list_cursor_engine import dllce_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [4:0]         func,
  input  logic signed [31:0] data_in,
  output logic               done,
  output logic signed [31:0] value_out,
  output logic               error,
  output logic               active
);

  cmd_t    cmd;
  status_t status;
  logic    go;

  // Take a transfer only while idle
  assign go = start && !busy;

  dllce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (go),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dllce_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_in   (data_in),
    .status    (status),
    .value_out (value_out),
    .error     (error),
    .active    (active)
  );

endmodule

// ----- bench/tb_doubly_linked_list_cursor_engine.sv -----
// Testbench for the doubly linked list cursor engine.
// Drives list operations, predicts each result with a local list model, checks every result.
// Depends on dllce_pkg and doubly_linked_list_cursor_engine.
`timescale 1ns / 100ps

module tb_doubly_linked_list_cursor_engine import dllce_pkg::*;;

  localparam int NODES = 64;
  localparam logic [6:0] NIL = 7'd64;
  localparam int LIMIT = 200000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               err;
    logic               act;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [4:0]         func = '0;
  logic signed [31:0] data_in = '0;
  logic               busy, done, error, active;
  logic signed [31:0] value_out;

  // Local copy of the list state
  logic [31:0] lst_val [NODES];
  logic [6:0]  lst_next [NODES];
  logic [6:0]  lst_prev [NODES];
  logic [6:0]  lst_head, lst_tail, lst_cur, lst_free, lst_bump;

  outcome_t    pending_q[$];
  int          mismatches = 0;
  int          checked = 0;
  int          sent = 0;
  int          cycles = 0;
  bit          sender_gaps = 1'b1;

  doubly_linked_list_cursor_engine u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .data_in(data_in),
    .done(done), .value_out(value_out), .error(error), .active(active)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        outcome_t e;
        e = pending_q.pop_front();
        checked++;
        if (e.value !== value_out || e.err !== error || e.act !== active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected value %0d err %0b act %0b, got %0d %0b %0b",
                     checked, e.value, e.err, e.act, value_out, error, active);
        end
      end
    end
  end

  function automatic void list_clear();
    lst_head = NIL; lst_tail = NIL; lst_cur = NIL; lst_free = NIL; lst_bump = '0;
  endfunction

  function automatic logic [6:0] node_alloc();
    logic [6:0] n;
    n = NIL;
    if (lst_free < NIL) begin
      n = lst_free;
      lst_free = lst_next[n];
    end else if (lst_bump < NIL) begin
      n = lst_bump;
      lst_bump = lst_bump + 7'd1;
    end
    return n;
  endfunction

  function automatic void node_free(logic [6:0] n);
    lst_next[n] = lst_free;
    lst_free = n;
  endfunction

  // Apply one operation to the local list and return its result
  function automatic outcome_t list_apply(logic [4:0] f, logic [31:0] d);
    outcome_t r;
    logic [6:0] n, m, c, o;
    r = '0;
    c = lst_cur;
    case (f)
      OP_CLEAR: list_clear();
      OP_INS_FIRST, OP_INS_LAST: begin
        n = node_alloc();
        if (n == NIL) r.err = 1'b1;
        else begin
          lst_val[n] = d;
          if (f == OP_INS_FIRST) begin
            lst_next[n] = lst_head; lst_prev[n] = NIL;
            if (lst_head < NIL) lst_prev[lst_head] = n; else lst_tail = n;
            lst_head = n;
          end else begin
            lst_next[n] = NIL; lst_prev[n] = lst_tail;
            if (lst_tail < NIL) lst_next[lst_tail] = n; else lst_head = n;
            lst_tail = n;
          end
        end
      end
      OP_CUR_FIRST: lst_cur = lst_head;
      OP_CUR_LAST: lst_cur = lst_tail;
      OP_GET_FIRST: if (lst_head < NIL) r.value = lst_val[lst_head]; else r.err = 1'b1;
      OP_GET_LAST: if (lst_tail < NIL) r.value = lst_val[lst_tail]; else r.err = 1'b1;
      OP_DEL_FIRST, OP_DEL_LAST: begin
        n = (f == OP_DEL_FIRST) ? lst_head : lst_tail;
        if (n < NIL) begin
          if (lst_cur == n) lst_cur = NIL;
          if (lst_head == lst_tail) begin
            lst_head = NIL; lst_tail = NIL;
          end else if (f == OP_DEL_FIRST) begin
            lst_head = lst_next[n]; lst_prev[lst_head] = NIL;
          end else begin
            lst_tail = lst_prev[n]; lst_next[lst_tail] = NIL;
          end
          node_free(n);
        end
      end
      OP_DEL_AFTER: if (c < NIL && c != lst_tail && lst_next[c] < NIL) begin
        n = lst_next[c]; m = lst_next[n];
        lst_next[c] = m;
        if (n == lst_tail || m >= NIL) lst_tail = c; else lst_prev[m] = c;
        node_free(n);
      end
      OP_DEL_BEF: if (c < NIL && c != lst_head && lst_prev[c] < NIL) begin
        n = lst_prev[c]; m = lst_prev[n];
        lst_prev[c] = m;
        if (n == lst_head || m >= NIL) lst_head = c; else lst_next[m] = c;
        node_free(n);
      end
      OP_INS_AFTER, OP_INS_BEF: if (c < NIL) begin
        n = node_alloc();
        if (n == NIL) r.err = 1'b1;
        else begin
          lst_val[n] = d;
          if (f == OP_INS_AFTER) begin
            o = lst_next[c];
            lst_next[n] = o; lst_prev[n] = c; lst_next[c] = n;
            if (c == lst_tail || o >= NIL) lst_tail = n; else lst_prev[o] = n;
          end else begin
            o = lst_prev[c];
            lst_next[n] = c; lst_prev[n] = o; lst_prev[c] = n;
            if (c == lst_head || o >= NIL) lst_head = n; else lst_next[o] = n;
          end
        end
      end
      OP_GET_ACT: if (c < NIL) r.value = lst_val[c]; else r.err = 1'b1;
      OP_SET_ACT: if (c < NIL) lst_val[c] = d;
      OP_CUR_PREV: if (c < NIL) lst_cur = lst_prev[c];
      OP_CUR_NEXT: if (c < NIL) lst_cur = lst_next[c];
      default: ;
    endcase
    r.act = (lst_cur < NIL);
    return r;
  endfunction

  // Send one operation: optional gap, wait for idle, one transfer
  task automatic send_op(input logic [4:0] f, input logic [31:0] d);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    func <= f;
    data_in <= d;
    @(posedge clk);
    pending_q.push_back(list_apply(f, d));
    sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Extremes, empty-list reads, cursor corner cases
  task automatic test_directed();
    send_op(OP_GET_FIRST, 0);
    send_op(OP_GET_LAST, 0);
    send_op(OP_GET_ACT, 0);
    send_op(OP_DEL_FIRST, 0);
    send_op(OP_INS_AFTER, 32'h1234);
    send_op(OP_SET_ACT, 32'h55);
    send_op(OP_CUR_FIRST, 0);
    send_op(OP_INS_FIRST, 32'h8000_0000);
    send_op(OP_INS_LAST, 32'h7FFF_FFFF);
    send_op(OP_INS_LAST, 32'hFFFF_FFFF);
    send_op(OP_CUR_FIRST, 0);
    send_op(OP_INS_BEF, 32'h0);
    send_op(OP_DEL_BEF, 0);
    send_op(OP_DEL_AFTER, 0);
    send_op(OP_CUR_LAST, 0);
    send_op(OP_DEL_AFTER, 0);
    send_op(OP_SET_ACT, 32'hA5A5_5A5A);
    send_op(OP_GET_ACT, 0);
    send_op(OP_CUR_PREV, 0);
    send_op(OP_IS_ACT, 0);
    send_op(OP_CUR_NEXT, 0);
    send_op(OP_CUR_NEXT, 0);
    send_op(OP_DEL_LAST, 0);
    send_op(5'd18, 32'hFFFF_FFFF);
    send_op(5'd31, 0);
  endtask

  // Fill the pool past capacity, then exercise free-chain reuse and clear
  task automatic test_pool_full();
    send_op(OP_CLEAR, 0);
    repeat (NODES + 2) send_op(OP_INS_LAST, $urandom());
    send_op(OP_CUR_FIRST, 0);
    send_op(OP_INS_AFTER, $urandom());
    send_op(OP_INS_BEF, $urandom());
    send_op(OP_DEL_AFTER, 0);
    send_op(OP_DEL_FIRST, 0);
    send_op(OP_INS_FIRST, $urandom());
    send_op(OP_INS_FIRST, $urandom());
    send_op(OP_GET_FIRST, 0);
    send_op(OP_GET_LAST, 0);
    // hold off until every result is back
    drain_results();
    send_op(OP_CLEAR, 0);
    send_op(OP_GET_FIRST, 0);
    send_op(OP_INS_LAST, $urandom());
  endtask

  // Random operations, biased towards inserts so lists grow and cursors move
  task automatic test_random(input int count);
    int k, sel;
    logic [4:0] f;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) f = $urandom_range(0, 1) ? OP_INS_LAST : OP_INS_FIRST;
      else if (sel < 40) f = $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEF;
      else if (sel < 41) f = OP_CLEAR;
      else if (sel < 43) f = 5'($urandom_range(18, 31));
      else f = 5'($urandom_range(1, 17));
      if (k % 200 == 100) sender_gaps = ~sender_gaps;
      send_op(f, $urandom());
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    list_clear();
    for (int i = 0; i < NODES; i++) begin
      lst_val[i] = '0; lst_next[i] = '0; lst_prev[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    test_random(900);
    drain_results();
    repeat (10) @(negedge clk);
    $display("Covered %0d operations, %0d results checked, incl. pool overflow and clear.",
             sent, checked);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
